>>> design/imu_ctf_pkg.sv
package imu_ctf_pkg;

    localparam int AXIS_W    = 16;
    localparam int CORR_W    = 17;
    localparam int TILT_V_W  = 18;
    localparam int ANGLE_W   = 25;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CORDIC_N  = 18;
    localparam int ATAN_W    = 23;

    localparam logic signed [ANGLE_W-1:0] ANG_LIMIT = 25'sd11796480;
    localparam logic signed [25:0]        YAW_K_Q40 = 26'sd11717;
    localparam logic [16:0]               W_ONE     = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GYRO_OFF_X  = 3'd0,
        REG_GYRO_OFF_Y  = 3'd1,
        REG_GYRO_OFF_Z  = 3'd2,
        REG_ACCEL_OFF_X = 3'd3,
        REG_ACCEL_OFF_Y = 3'd4,
        REG_ACCEL_OFF_Z = 3'd5,
        REG_RATE_GAIN   = 3'd6,
        REG_GYRO_WEIGHT = 3'd7
    } cfg_reg_t;

    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_N] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117305,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29
    };

    typedef struct packed {
        logic                        start;
        logic signed [TILT_V_W-1:0]  v;
        logic [33:0]                 sum;
    } tilt_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [ANGLE_W-1:0]   angle;
    } tilt_rsp_t;

endpackage

>>> design/imu_complementary_tilt_filter.sv
// Each result is set by two passes of the shared tilt unit (32-step square
// root, 18-step CORDIC) and 12 steps of the shared multiplier; both tilt
// passes are skipped when all corrected accel axes are zero.
// A new item is taken only in idle, once the last result has moved to the
// output register, which waits while a held result is not taken; input is
// not ready while busy.
// Reset: rst_n asynchronous active low; clears angle estimates, restores
// register defaults and drops the result valid.
module imu_complementary_tilt_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // gyro_x_raw, gyro_y_raw, gyro_z_raw, accel_x_raw, accel_y_raw, accel_z_raw
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pitch_angle, roll_angle, zero pad
    output logic [55:0] m_tdata,
    // accel_zero
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int CW = imu_ctf_pkg::CORR_W;
    localparam int AW = imu_ctf_pkg::ANGLE_W;
    localparam int VW = imu_ctf_pkg::TILT_V_W;

    typedef enum logic [4:0] {
        S_IDLE, S_TH, S_INC_P, S_INC_R, S_YAW_W, S_YAW_P, S_YAW_PC, S_YAW_R,
        S_SQ_Z, S_SQ_X, S_SQ_Y, S_SQ_END, S_TILT_P, S_TILT_R,
        S_BL_P0, S_BL_P1, S_BL_R0, S_BL_R1, S_BL_END, S_DONE
    } state_t;

    state_t state_reg;

    logic signed [15:0] goff_x_reg, goff_y_reg, goff_z_reg;
    logic signed [15:0] aoff_x_reg, aoff_y_reg, aoff_z_reg;
    logic [31:0]        gain_reg;
    logic [16:0]        weight_reg;

    logic signed [CW-1:0] gx_reg, gy_reg, gz_reg, ax_reg, ay_reg, az_reg;
    logic                 zero_reg;
    logic signed [30:0]   theta_reg;
    logic signed [AW-1:0] pitch_reg, roll_reg, pitch_est_reg, roll_est_reg;
    logic signed [AW-1:0] acc_p_reg, acc_r_reg;
    logic [33:0]          sqx_reg, sqz_reg;
    logic signed [59:0]   prod_reg, sum_reg;
    logic signed [33:0]   mul_a;
    logic signed [25:0]   mul_b;

    logic [AW-1:0] m_pitch_reg, m_roll_reg;
    logic          m_valid_reg, m_zero_reg;

    imu_ctf_pkg::tilt_req_t tilt_req_reg;
    imu_ctf_pkg::tilt_rsp_t tilt_rsp;

    logic signed [CW-1:0] cx, cy, cz, dax, day, daz;
    logic [16:0]          w_eff, w_acc;
    logic signed [59:0]   rnd16, rnd40, rndbl;

    function automatic logic signed [59:0] rshift(input logic signed [59:0] v,
                                                  input logic [5:0] s);
        logic [59:0] mag;
        logic [59:0] m;
        mag = v[59] ? 60'(-v) : 60'(v);
        m   = (mag + (60'(1) << (s - 6'd1))) >> s;
        return v[59] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [AW-1:0] sat(input logic signed [35:0] v);
        if (v > 36'(imu_ctf_pkg::ANG_LIMIT))
            return imu_ctf_pkg::ANG_LIMIT;
        else if (v < -36'(imu_ctf_pkg::ANG_LIMIT))
            return -imu_ctf_pkg::ANG_LIMIT;
        else
            return v[AW-1:0];
    endfunction

    function automatic logic signed [35:0] ext(input logic signed [AW-1:0] v);
        return {{(36-AW){v[AW-1]}}, v};
    endfunction

    imu_ctf_tilt u_tilt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tilt_req_reg),
        .rsp   (tilt_rsp)
    );

    always_comb
    begin
        cx    = CW'($signed(s_tdata[15:0]))  + CW'(goff_x_reg);
        cy    = CW'($signed(s_tdata[31:16])) + CW'(goff_y_reg);
        cz    = CW'($signed(s_tdata[47:32])) + CW'(goff_z_reg);
        dax   = CW'($signed(s_tdata[63:48])) + CW'(aoff_x_reg);
        day   = CW'($signed(s_tdata[79:64])) + CW'(aoff_y_reg);
        daz   = CW'($signed(s_tdata[95:80])) + CW'(aoff_z_reg);
        w_eff = (weight_reg > imu_ctf_pkg::W_ONE) ? imu_ctf_pkg::W_ONE : weight_reg;
        w_acc = imu_ctf_pkg::W_ONE - w_eff;
        rnd16 = rshift(prod_reg, 6'd16);
        rnd40 = rshift(prod_reg, 6'd40);
        rndbl = rshift(sum_reg + prod_reg, 6'd16);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TH:    begin mul_a = 34'(gz_reg); mul_b = imu_ctf_pkg::YAW_K_Q40; end
            S_INC_P: begin mul_a = $signed({2'b0, gain_reg}); mul_b = 26'(gy_reg); end
            S_INC_R: begin mul_a = $signed({2'b0, gain_reg}); mul_b = 26'(gx_reg); end
            S_YAW_P: begin mul_a = 34'(theta_reg); mul_b = 26'(roll_reg); end
            S_YAW_R: begin mul_a = 34'(theta_reg); mul_b = 26'(pitch_reg); end
            S_SQ_Z:  begin mul_a = 34'(az_reg); mul_b = 26'(az_reg); end
            S_SQ_X:  begin mul_a = 34'(ax_reg); mul_b = 26'(ax_reg); end
            S_SQ_Y:  begin mul_a = 34'(ay_reg); mul_b = 26'(ay_reg); end
            S_BL_P0: begin mul_a = $signed({17'd0, w_eff}); mul_b = 26'(pitch_reg); end
            S_BL_P1: begin mul_a = $signed({17'd0, w_acc}); mul_b = 26'(acc_p_reg); end
            S_BL_R0: begin mul_a = $signed({17'd0, w_eff}); mul_b = 26'(roll_reg); end
            S_BL_R1: begin mul_a = $signed({17'd0, w_acc}); mul_b = 26'(acc_r_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            goff_x_reg    <= 16'sd85;
            goff_y_reg    <= -16'sd35;
            goff_z_reg    <= 16'sd80;
            aoff_x_reg    <= -16'sd300;
            aoff_y_reg    <= -16'sd50;
            aoff_z_reg    <= 16'sd600;
            gain_reg      <= 32'd262288;
            weight_reg    <= 17'd62259;
            pitch_est_reg <= '0;
            roll_est_reg  <= '0;
            m_valid_reg   <= 1'b0;
            tilt_req_reg  <= '0;
        end
        else
        begin
            prod_reg           <= mul_a * mul_b;
            tilt_req_reg.start <= 1'b0;
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (imu_ctf_pkg::cfg_reg_t'(cfg_addr))
                    imu_ctf_pkg::REG_GYRO_OFF_X:  goff_x_reg <= cfg_wdata[15:0];
                    imu_ctf_pkg::REG_GYRO_OFF_Y:  goff_y_reg <= cfg_wdata[15:0];
                    imu_ctf_pkg::REG_GYRO_OFF_Z:  goff_z_reg <= cfg_wdata[15:0];
                    imu_ctf_pkg::REG_ACCEL_OFF_X: aoff_x_reg <= cfg_wdata[15:0];
                    imu_ctf_pkg::REG_ACCEL_OFF_Y: aoff_y_reg <= cfg_wdata[15:0];
                    imu_ctf_pkg::REG_ACCEL_OFF_Z: aoff_z_reg <= cfg_wdata[15:0];
                    imu_ctf_pkg::REG_RATE_GAIN:   gain_reg   <= cfg_wdata;
                    imu_ctf_pkg::REG_GYRO_WEIGHT: weight_reg <= cfg_wdata[16:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        gx_reg    <= cx;
                        gy_reg    <= cy;
                        gz_reg    <= cz;
                        ax_reg    <= dax;
                        ay_reg    <= day;
                        az_reg    <= daz;
                        zero_reg  <= (dax == '0) && (day == '0) && (daz == '0);
                        state_reg <= S_TH;
                    end
                end
                S_TH:    state_reg <= S_INC_P;
                S_INC_P:
                begin
                    theta_reg <= prod_reg[30:0];
                    state_reg <= S_INC_R;
                end
                S_INC_R:
                begin
                    pitch_reg <= sat(ext(pitch_est_reg) + rnd16[35:0]);
                    state_reg <= S_YAW_W;
                end
                S_YAW_W:
                begin
                    roll_reg  <= sat(ext(roll_est_reg) + rnd16[35:0]);
                    state_reg <= S_YAW_P;
                end
                S_YAW_P: state_reg <= S_YAW_PC;
                S_YAW_PC:
                begin
                    pitch_reg <= sat(ext(pitch_reg) + rnd40[35:0]);
                    state_reg <= S_YAW_R;
                end
                S_YAW_R: state_reg <= S_SQ_Z;
                S_SQ_Z:
                begin
                    roll_reg  <= sat(ext(roll_reg) - rnd40[35:0]);
                    state_reg <= S_SQ_X;
                end
                S_SQ_X:
                begin
                    sqz_reg   <= prod_reg[33:0];
                    state_reg <= S_SQ_Y;
                end
                S_SQ_Y:
                begin
                    sqx_reg   <= prod_reg[33:0];
                    state_reg <= S_SQ_END;
                end
                S_SQ_END:
                begin
                    acc_p_reg <= '0;
                    acc_r_reg <= '0;
                    if (zero_reg)
                    begin
                        state_reg <= S_BL_P0;
                    end
                    else
                    begin
                        tilt_req_reg.start <= 1'b1;
                        tilt_req_reg.v     <= -(VW'(ax_reg));
                        tilt_req_reg.sum   <= prod_reg[33:0] + sqz_reg;
                        state_reg          <= S_TILT_P;
                    end
                end
                S_TILT_P:
                begin
                    if (tilt_rsp.done)
                    begin
                        acc_p_reg          <= tilt_rsp.angle;
                        tilt_req_reg.start <= 1'b1;
                        tilt_req_reg.v     <= VW'(ay_reg);
                        tilt_req_reg.sum   <= sqx_reg + sqz_reg;
                        state_reg          <= S_TILT_R;
                    end
                end
                S_TILT_R:
                begin
                    if (tilt_rsp.done)
                    begin
                        acc_r_reg <= tilt_rsp.angle;
                        state_reg <= S_BL_P0;
                    end
                end
                S_BL_P0: state_reg <= S_BL_P1;
                S_BL_P1:
                begin
                    sum_reg   <= prod_reg;
                    state_reg <= S_BL_R0;
                end
                S_BL_R0:
                begin
                    pitch_reg <= sat(rndbl[35:0]);
                    state_reg <= S_BL_R1;
                end
                S_BL_R1:
                begin
                    sum_reg   <= prod_reg;
                    state_reg <= S_BL_END;
                end
                S_BL_END:
                begin
                    roll_reg  <= sat(rndbl[35:0]);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_pitch_reg   <= pitch_reg;
                        m_roll_reg    <= roll_reg;
                        m_zero_reg    <= zero_reg;
                        m_valid_reg   <= 1'b1;
                        pitch_est_reg <= pitch_reg;
                        roll_est_reg  <= roll_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_roll_reg, m_pitch_reg};
    assign m_tuser  = m_zero_reg;

endmodule

>>> design/imu_ctf_tilt.sv
module imu_ctf_tilt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  imu_ctf_pkg::tilt_req_t req,
    output imu_ctf_pkg::tilt_rsp_t rsp
);

    typedef enum logic [1:0] {T_IDLE, T_SQRT, T_CORD} tstate_t;

    tstate_t            state_reg;
    logic [62:0]        n_reg;
    logic [62:0]        res_reg;
    logic [62:0]        bit_reg;
    logic signed [45:0] x_reg;
    logic signed [45:0] y_reg;
    logic signed [25:0] z_reg;
    logic [4:0]         i_reg;
    logic signed [imu_ctf_pkg::TILT_V_W-1:0] v_reg;
    logic               done_reg;

    logic [63:0]        trial;
    logic               take;
    logic [62:0]        res_next;
    logic signed [45:0] dx;
    logic signed [45:0] dy;
    logic signed [25:0] atan_s;

    always_comb
    begin
        trial    = {1'b0, res_reg} + {1'b0, bit_reg};
        take     = {1'b0, n_reg} >= trial;
        res_next = take ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        dx       = y_reg >>> i_reg;
        dy       = x_reg >>> i_reg;
        atan_s   = 26'(imu_ctf_pkg::ATAN_TAB[i_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                T_IDLE:
                begin
                    if (req.start)
                    begin
                        n_reg     <= {1'b0, req.sum, 28'd0};
                        res_reg   <= '0;
                        bit_reg   <= 63'(1) << 62;
                        v_reg     <= req.v;
                        state_reg <= T_SQRT;
                    end
                end
                T_SQRT:
                begin
                    if (take)
                    begin
                        n_reg <= n_reg - trial[62:0];
                    end
                    res_reg <= res_next;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        x_reg     <= $signed({4'd0, res_next[31:0], 10'd0});
                        y_reg     <= $signed({{4{v_reg[imu_ctf_pkg::TILT_V_W-1]}}, v_reg,
                                              24'd0});
                        z_reg     <= '0;
                        i_reg     <= '0;
                        state_reg <= T_CORD;
                    end
                end
                T_CORD:
                begin
                    if (!y_reg[45])
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_s;
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_s;
                    end
                    i_reg <= i_reg + 5'd1;
                    if (i_reg == 5'(imu_ctf_pkg::CORDIC_N - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = z_reg[imu_ctf_pkg::ANGLE_W-1:0];

endmodule

>>> design/imu_ctf_checker.sv
module imu_ctf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // drop ready for the item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[24:0]) <= 25'sd11796480)
                  && ($signed(m_tdata[24:0]) >= -25'sd11796480))
        else $error("pitch out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[49:25]) <= 25'sd11796480)
                  && ($signed(m_tdata[49:25]) >= -25'sd11796480))
        else $error("roll out of range");

endmodule

bind imu_complementary_tilt_filter imu_ctf_checker u_imu_ctf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     TAIL_WAIT   = 300;
    localparam longint LIM         = 11796480;

    typedef struct {
        logic signed [imu_ctf_pkg::ANGLE_W-1:0] pitch;
        logic signed [imu_ctf_pkg::ANGLE_W-1:0] roll;
        logic                                   zero;
    } tilt_out_t;

    class tilt_scoreboard;
        longint            gyro_off[3];
        longint            accel_off[3];
        longint unsigned   gain;
        longint unsigned   weight;
        longint            pitch_est;
        longint            roll_est;
        tilt_out_t         pending[$];
        int                errors;

        function new();
            gyro_off  = '{85, -35, 80};
            accel_off = '{-300, -50, 600};
            gain      = 262288;
            weight    = 62259;
            pitch_est = 0;
            roll_est  = 0;
            errors    = 0;
        endfunction

        function void write_reg(imu_ctf_pkg::cfg_reg_t idx, logic [31:0] val);
            case (idx)
                imu_ctf_pkg::REG_GYRO_OFF_X:  gyro_off[0]  = longint'($signed(val[15:0]));
                imu_ctf_pkg::REG_GYRO_OFF_Y:  gyro_off[1]  = longint'($signed(val[15:0]));
                imu_ctf_pkg::REG_GYRO_OFF_Z:  gyro_off[2]  = longint'($signed(val[15:0]));
                imu_ctf_pkg::REG_ACCEL_OFF_X: accel_off[0] = longint'($signed(val[15:0]));
                imu_ctf_pkg::REG_ACCEL_OFF_Y: accel_off[1] = longint'($signed(val[15:0]));
                imu_ctf_pkg::REG_ACCEL_OFF_Z: accel_off[2] = longint'($signed(val[15:0]));
                imu_ctf_pkg::REG_RATE_GAIN:   gain   = val;
                imu_ctf_pkg::REG_GYRO_WEIGHT: weight = val[16:0];
                default: ;
            endcase
        endfunction

        function longint round_shr(longint v, int s);
            longint unsigned m;
            m = (v < 0) ? longint'(-v) : v;
            m = (m + (64'd1 << (s - 1))) >> s;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint clamp(longint v);
            if (v > LIM) return LIM;
            if (v < -LIM) return -LIM;
            return v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, bit_v;
            res = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > n) bit_v >>= 2;
            while (bit_v != 0) begin
                if (n >= res + bit_v) begin
                    n -= res + bit_v;
                    res = (res >> 1) + bit_v;
                end else begin
                    res >>= 1;
                end
                bit_v >>= 2;
            end
            return res;
        endfunction

        function longint tilt_angle(longint v, longint p, longint q);
            longint unsigned s;
            longint x, y, z, dx, dy;
            s = longint'(p * p) + longint'(q * q);
            x = longint'(int_sqrt(s << 28)) * 1024;
            y = v * 16777216;
            z = 0;
            for (int i = 0; i < imu_ctf_pkg::CORDIC_N; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += longint'(imu_ctf_pkg::ATAN_TAB[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(imu_ctf_pkg::ATAN_TAB[i]);
                end
            end
            return z;
        endfunction

        function void note_input(logic [95:0] d);
            longint g[3], a[3];
            longint w, pitch, roll, theta, acc_p, acc_r;
            tilt_out_t e;
            for (int i = 0; i < 3; i++) begin
                g[i] = longint'($signed(d[16*i +: 16])) + gyro_off[i];
                a[i] = longint'($signed(d[48 + 16*i +: 16])) + accel_off[i];
            end
            w = (weight > 65536) ? 65536 : longint'(weight);
            e.zero = (a[0] == 0 && a[1] == 0 && a[2] == 0);
            pitch = clamp(pitch_est + round_shr(g[1] * longint'(gain), 16));
            roll  = clamp(roll_est + round_shr(g[0] * longint'(gain), 16));
            theta = g[2] * 11717;
            pitch = clamp(pitch + round_shr(roll * theta, 40));
            roll  = clamp(roll - round_shr(pitch * theta, 40));
            acc_p = 0;
            acc_r = 0;
            if (!e.zero) begin
                acc_p = tilt_angle(-a[0], a[1], a[2]);
                acc_r = tilt_angle(a[1], a[0], a[2]);
            end
            pitch = clamp(round_shr(w * pitch + (65536 - w) * acc_p, 16));
            roll  = clamp(round_shr(w * roll + (65536 - w) * acc_r, 16));
            pitch_est = pitch;
            roll_est  = roll;
            e.pitch = pitch[imu_ctf_pkg::ANGLE_W-1:0];
            e.roll  = roll[imu_ctf_pkg::ANGLE_W-1:0];
            pending.push_back(e);
        endfunction

        function void check_result(logic [55:0] d, logic u);
            tilt_out_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result pitch=%0d roll=%0d zero=%0b", $realtime,
                         $signed(d[24:0]), $signed(d[49:25]), u);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[24:0] !== e.pitch) begin
                $display("%0t: pitch expected %0d actual %0d", $realtime, e.pitch,
                         $signed(d[24:0]));
                errors++;
            end
            if (d[49:25] !== e.roll) begin
                $display("%0t: roll expected %0d actual %0d", $realtime, e.roll,
                         $signed(d[49:25]));
                errors++;
            end
            if (u !== e.zero) begin
                $display("%0t: accel_zero expected %0b actual %0b", $realtime, e.zero, u);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    tilt_scoreboard sb;
    longint cycles;
    bit     quiet;
    int     hold_req;
    int     hold_seen;
    int     ready_left;

    imu_complementary_tilt_filter uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // output side: check, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (hold_req != hold_seen)
        begin
            hold_seen  = hold_req;
            ready_left = 700;
            m_tready  <= 1'b0;
        end else if (ready_left > 0)
        begin
            ready_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            ready_left = $urandom_range(0, 13);
            m_tready  <= 1'b0;
        end else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(logic [95:0] d);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(imu_ctf_pkg::cfg_reg_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    function automatic logic [15:0] neg16(longint off);
        return 16'(-off);
    endfunction

    function automatic logic [95:0] zero_accel_item();
        logic [95:0] d;
        d = {$urandom, $urandom, $urandom};
        d[63:48] = neg16(sb.accel_off[0]);
        d[79:64] = neg16(sb.accel_off[1]);
        d[95:80] = neg16(sb.accel_off[2]);
        return d;
    endfunction

    function automatic bit zero_reachable();
        return sb.accel_off[0] != -32768 && sb.accel_off[1] != -32768 &&
               sb.accel_off[2] != -32768;
    endfunction

    function automatic logic [95:0] random_item();
        logic [95:0] d;
        int k;
        d = {$urandom, $urandom, $urandom};
        k = $urandom_range(0, 9);
        if (k == 0 && zero_reachable())
            d = zero_accel_item();
        else if (k < 4)
        begin
            for (int i = 0; i < 6; i++)
                d[16*i +: 16] = 16'($signed($urandom_range(0, 400)) - 200);
        end else if (k == 4)
        begin
            for (int i = 0; i < 6; i++)
                d[16*i +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        end
        return d;
    endfunction

    task automatic configure(logic [31:0] vals[8]);
        drain();
        repeat (TAIL_WAIT) @(posedge clk);
        for (int i = 0; i < 8; i++)
            write_reg(imu_ctf_pkg::cfg_reg_t'(i), vals[i]);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] vals[8];
        sb         = new();
        quiet      = 1'b0;
        hold_req   = 0;
        hold_seen  = 0;
        ready_left = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item('0);
        send_item({6{16'h7fff}});
        send_item({6{16'h8000}});
        send_item({16'hfda8, 16'h0032, 16'h012c, 16'h0000, 16'h0000, 16'h0000});
        send_item({16'hfda8, 16'h0032, 16'h012c, 16'h7fff, 16'h8000, 16'h7fff});
        send_item({16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000});
        send_item({16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_item({16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000});
        send_item({16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000});
        for (int i = 0; i < 12; i++) send_item({16'h0258, 16'hffce, 16'h012c,
                                                16'h7fff, 16'h7fff, 16'h7fff});
        for (int i = 0; i < 4; i++) send_item(random_item());

        for (int ph = 0; ph < 8; ph++)
        begin
            for (int i = 0; i < 6; i++) vals[i] = $urandom;
            vals[6] = $urandom;
            vals[7] = $urandom_range(0, 65536);
            case (ph)
                0: begin vals[6] = 32'hffffffff; vals[7] = 32'd65536; end
                1: begin vals[6] = 32'd0; vals[7] = 32'd0; end
                2: begin vals[7] = 32'h1ffff; vals[6] = $urandom_range(0, 2000000); end
                3: begin
                    vals[0] = 32'h8000; vals[1] = 32'h7fff; vals[2] = 32'h8000;
                    vals[3] = 32'h7fff; vals[4] = 32'h7fff; vals[5] = 32'h7fff;
                    vals[7] = 32'd65535;
                end
                4: begin
                    vals[0] = 32'h7fff; vals[1] = 32'h8000; vals[2] = 32'h7fff;
                    vals[3] = 32'h8000; vals[4] = 32'h8000; vals[5] = 32'h8000;
                    vals[7] = 32'd1;
                end
                5: vals[6] = $urandom_range(0, 4000000);
                default: ;
            endcase
            configure(vals);
            if (ph == 7) quiet = 1'b1;
            for (int i = 0; i < 125; i++)
            begin
                if (ph == 2 && i == 10) hold_req++;
                if (ph == 5 && i == 60)
                begin
                    drain();
                end
                send_item(random_item());
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> imu_complementary_tilt_filter.f
design/imu_ctf_pkg.sv
design/imu_ctf_tilt.sv
design/imu_complementary_tilt_filter.sv
design/imu_ctf_checker.sv
tb/testbench.sv
